>>> design/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants and types for the ray/triangle intersection block.
// ----------------------------------------------------------------------------
package rti_pkg;

    localparam int COORD_BITS_DEF = 20;
    localparam int DIST_FRAC      = 16;
    localparam int DIST_W         = 32;
    localparam int QUO_BITS       = DIST_W - 1;
    localparam int VERTEX_W       = 60;
    localparam int APB_DW         = 64;
    localparam int APB_AW         = 5;

    typedef enum logic [1:0] {
        REG_VERTEX_A = 2'd0,
        REG_VERTEX_B = 2'd1,
        REG_VERTEX_C = 2'd2
    } t_reg_idx;

endpackage

>>> design/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Moller-Trumbore ray/triangle test against a triangle held in registers.
// ----------------------------------------------------------------------------
// One ray transfer per clock is accepted while the pipeline is not frozen;
// results leave in order, and the quotient t = tn/det is found one bit per stage.
// The pipeline freezes only while the output holds a result that is stalled.
// Vertices are written through the APB port at byte addresses 0, 8 and 16.
module ray_triangle_intersect #(
    parameter int COORD_BITS = rti_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rti_pkg::APB_AW-1:0]        paddr,
    input  logic [rti_pkg::APB_DW-1:0]        pwdata,
    output logic [rti_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [COORD_BITS-1:0]      i_origin_x,
    input  logic signed [COORD_BITS-1:0]      i_origin_y,
    input  logic signed [COORD_BITS-1:0]      i_origin_z,
    input  logic signed [COORD_BITS-1:0]      i_dir_x,
    input  logic signed [COORD_BITS-1:0]      i_dir_y,
    input  logic signed [COORD_BITS-1:0]      i_dir_z,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_hit,
    output logic signed [rti_pkg::DIST_W-1:0] o_distance,
    output logic signed [COORD_BITS-1:0]      o_point_x,
    output logic signed [COORD_BITS-1:0]      o_point_y,
    output logic signed [COORD_BITS-1:0]      o_point_z
);
    import rti_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int VW    = (3 * C > VERTEX_W) ? 3 * C : VERTEX_W;
    localparam int EW    = C + 1;
    localparam int XW    = 2 * C + 3;
    localparam int SW    = 3 * C + 6;
    localparam int RSW   = SW + 2;
    localparam int MW    = SW;
    localparam int REMW  = MW + QUO_BITS;
    localparam int CMPW  = MW + QUO_BITS - DIST_FRAC;
    localparam int SIDEW = 6 * C + 4;
    localparam int PW    = DIST_W + C;
    localparam int AW    = PW - DIST_FRAC + 1;
    localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (C - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

    // config registers
    logic [VW-1:0] r_vtx_a, r_vtx_b, r_vtx_c;
    t_reg_idx      w_idx;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx_a <= '0;
            r_vtx_b <= '0;
            r_vtx_c <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                REG_VERTEX_A: r_vtx_a <= VW'(pwdata);
                REG_VERTEX_B: r_vtx_b <= VW'(pwdata);
                REG_VERTEX_C: r_vtx_c <= VW'(pwdata);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_VERTEX_A: prdata = APB_DW'(r_vtx_a);
            REG_VERTEX_B: prdata = APB_DW'(r_vtx_b);
            REG_VERTEX_C: prdata = APB_DW'(r_vtx_c);
            default:      prdata = '0;
        endcase
    end

    // pipeline control
    logic w_adv;
    logic r_out_v;

    assign w_adv      = !r_out_v || !i_out_stall;
    assign o_in_stall = !w_adv;

    // stage 1: edges and origin offset
    logic signed [C-1:0]  w_va [3], w_vb [3], w_vc [3], w_o [3], w_d [3];
    logic                 r1_v;
    logic signed [C-1:0]  r1_o [3], r1_d [3];
    logic signed [EW-1:0] r1_e0 [3], r1_e1 [3], r1_s [3];

    always_comb begin
        w_o[0] = i_origin_x;
        w_o[1] = i_origin_y;
        w_o[2] = i_origin_z;
        w_d[0] = i_dir_x;
        w_d[1] = i_dir_y;
        w_d[2] = i_dir_z;
        for (int j = 0; j < 3; j++) begin
            w_va[j] = $signed(r_vtx_a[j*C +: C]);
            w_vb[j] = $signed(r_vtx_b[j*C +: C]);
            w_vc[j] = $signed(r_vtx_c[j*C +: C]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int j = 0; j < 3; j++) begin
                r1_o[j]  <= w_o[j];
                r1_d[j]  <= w_d[j];
                r1_e0[j] <= EW'(w_vb[j]) - EW'(w_va[j]);
                r1_e1[j] <= EW'(w_vc[j]) - EW'(w_va[j]);
                r1_s[j]  <= EW'(w_o[j]) - EW'(w_va[j]);
            end
        end
    end

    // stage 2: cross-product terms
    logic                 r2_v;
    logic signed [C-1:0]  r2_o [3], r2_d [3];
    logic signed [EW-1:0] r2_e0 [3], r2_e1 [3], r2_s [3];
    logic signed [XW-1:0] r2_pp [6], r2_qp [6];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_o  <= r1_o;
            r2_d  <= r1_d;
            r2_e0 <= r1_e0;
            r2_e1 <= r1_e1;
            r2_s  <= r1_s;
            r2_pp[0] <= XW'(r1_d[1]) * XW'(r1_e1[2]);
            r2_pp[1] <= XW'(r1_d[2]) * XW'(r1_e1[1]);
            r2_pp[2] <= XW'(r1_d[2]) * XW'(r1_e1[0]);
            r2_pp[3] <= XW'(r1_d[0]) * XW'(r1_e1[2]);
            r2_pp[4] <= XW'(r1_d[0]) * XW'(r1_e1[1]);
            r2_pp[5] <= XW'(r1_d[1]) * XW'(r1_e1[0]);
            r2_qp[0] <= XW'(r1_s[1]) * XW'(r1_e0[2]);
            r2_qp[1] <= XW'(r1_s[2]) * XW'(r1_e0[1]);
            r2_qp[2] <= XW'(r1_s[2]) * XW'(r1_e0[0]);
            r2_qp[3] <= XW'(r1_s[0]) * XW'(r1_e0[2]);
            r2_qp[4] <= XW'(r1_s[0]) * XW'(r1_e0[1]);
            r2_qp[5] <= XW'(r1_s[1]) * XW'(r1_e0[0]);
        end
    end

    // stage 3: cross products pv = d x e1, qv = s x e0
    logic                 r3_v;
    logic signed [C-1:0]  r3_o [3], r3_d [3];
    logic signed [EW-1:0] r3_e0 [3], r3_e1 [3], r3_s [3];
    logic signed [XW-1:0] r3_pv [3], r3_qv [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_o  <= r2_o;
            r3_d  <= r2_d;
            r3_e0 <= r2_e0;
            r3_e1 <= r2_e1;
            r3_s  <= r2_s;
            for (int j = 0; j < 3; j++) begin
                r3_pv[j] <= r2_pp[2*j] - r2_pp[2*j+1];
                r3_qv[j] <= r2_qp[2*j] - r2_qp[2*j+1];
            end
        end
    end

    // stage 4: dot-product terms
    logic                 r4_v;
    logic signed [C-1:0]  r4_o [3], r4_d [3];
    logic signed [SW-1:0] r4_det [3], r4_tn [3], r4_u [3], r4_w [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_o <= r3_o;
            r4_d <= r3_d;
            for (int j = 0; j < 3; j++) begin
                r4_det[j] <= SW'(r3_pv[j]) * SW'(r3_e0[j]);
                r4_tn[j]  <= SW'(r3_qv[j]) * SW'(r3_e1[j]);
                r4_u[j]   <= SW'(r3_pv[j]) * SW'(r3_s[j]);
                r4_w[j]   <= SW'(r3_qv[j]) * SW'(r3_d[j]);
            end
        end
    end

    // stage 5: det, tn, u, v
    logic                 r5_v;
    logic signed [C-1:0]  r5_o [3], r5_d [3];
    logic signed [SW-1:0] r5_det, r5_tn, r5_u, r5_w;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_o   <= r4_o;
            r5_d   <= r4_d;
            r5_det <= r4_det[0] + r4_det[1] + r4_det[2];
            r5_tn  <= r4_tn[0] + r4_tn[1] + r4_tn[2];
            r5_u   <= r4_u[0] + r4_u[1] + r4_u[2];
            r5_w   <= r4_w[0] + r4_w[1] + r4_w[2];
        end
    end

    // stage 6: magnitudes, signs, barycentric remainder
    logic                  r6_v;
    logic signed [C-1:0]   r6_o [3], r6_d [3];
    logic signed [SW-1:0]  r6_u, r6_w, r6_tn;
    logic signed [RSW-1:0] r6_rest;
    logic [MW-1:0]         r6_nmag, r6_dmag;
    logic                  r6_dn, r6_zero, r6_neg;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_o    <= r5_o;
            r6_d    <= r5_d;
            r6_u    <= r5_u;
            r6_w    <= r5_w;
            r6_tn   <= r5_tn;
            r6_rest <= RSW'(r5_det) - RSW'(r5_u) - RSW'(r5_w);
            r6_nmag <= r5_tn[SW-1]  ? MW'(-r5_tn)  : MW'(r5_tn);
            r6_dmag <= r5_det[SW-1] ? MW'(-r5_det) : MW'(r5_det);
            r6_dn   <= r5_det[SW-1];
            r6_zero <= (r5_det == '0);
            r6_neg  <= r5_tn[SW-1] != r5_det[SW-1];
        end
    end

    // stage 7: hit test, saturation check, divider setup
    logic                  r7_v;
    logic [REMW-1:0]       r7_rem;
    logic [MW-1:0]         r7_den;
    logic [SIDEW-1:0]      r7_side;
    logic                  w7_hit, w7_sat;
    logic [SIDEW-1:0]      w7_side;

    always_comb begin
        w7_hit = !r6_zero
              && (r6_u == '0 || r6_u[SW-1] == r6_dn)
              && (r6_w == '0 || r6_w[SW-1] == r6_dn)
              && (r6_rest == '0 || r6_rest[RSW-1] == r6_dn)
              && (r6_tn == '0 || r6_tn[SW-1] == r6_dn);
        w7_sat = CMPW'(r6_nmag) >= (CMPW'(r6_dmag) << (QUO_BITS - DIST_FRAC));
        w7_side = {w7_hit, r6_zero, r6_neg, w7_sat,
                   r6_o[2], r6_o[1], r6_o[0], r6_d[2], r6_d[1], r6_d[0]};
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_rem  <= w7_sat ? '0 : (REMW'(r6_nmag) << DIST_FRAC);
            r7_den  <= r6_dmag;
            r7_side <= w7_side;
        end
    end

    // quotient
    logic                 w_dv;
    logic [QUO_BITS-1:0]  w_quo;
    logic [SIDEW-1:0]     w_dside;

    rti_div_pipe #(
        .MAG_W  (MW),
        .SIDE_W (SIDEW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r7_v),
        .i_rem   (r7_rem),
        .i_den   (r7_den),
        .i_side  (r7_side),
        .o_valid (w_dv),
        .o_quo   (w_quo),
        .o_side  (w_dside)
    );

    // stage 8: signed, saturated distance
    logic                       r8_v;
    logic                       r8_hit;
    logic signed [DIST_W-1:0]   r8_dist;
    logic signed [C-1:0]        r8_o [3], r8_d [3];
    logic                       w8_hit, w8_zero, w8_neg, w8_sat;
    logic [DIST_W-1:0]          w8_q;
    logic signed [DIST_W-1:0]   n8_dist;

    always_comb begin
        w8_hit  = w_dside[SIDEW-1];
        w8_zero = w_dside[SIDEW-2];
        w8_neg  = w_dside[SIDEW-3];
        w8_sat  = w_dside[SIDEW-4];
        w8_q    = w8_sat ? (DIST_W'(1) << QUO_BITS) : DIST_W'(w_quo);
        if (w8_zero) begin
            n8_dist = '0;
        end else if (w8_neg) begin
            n8_dist = $signed(DIST_W'(0) - w8_q);
        end else if (w8_sat) begin
            n8_dist = $signed({1'b0, {QUO_BITS{1'b1}}});
        end else begin
            n8_dist = $signed(w8_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_hit  <= w8_hit;
            r8_dist <= n8_dist;
            for (int j = 0; j < 3; j++) begin
                r8_o[j] <= $signed(w_dside[(3+j)*C +: C]);
                r8_d[j] <= $signed(w_dside[j*C +: C]);
            end
        end
    end

    // stage 9: distance times direction
    logic                 r9_v;
    logic                 r9_hit;
    logic signed [DIST_W-1:0] r9_dist;
    logic signed [C-1:0]  r9_o [3];
    logic signed [PW-1:0] r9_p [3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r9_hit  <= r8_hit;
            r9_dist <= r8_dist;
            r9_o    <= r8_o;
            for (int j = 0; j < 3; j++) begin
                r9_p[j] <= PW'(r8_dist) * PW'(r8_d[j]);
            end
        end
    end

    // stage 10: point = origin + floor(p / 2^16), saturated
    logic                 r_hit;
    logic signed [DIST_W-1:0] r_dist;
    logic signed [C-1:0]  r_pt [3];
    logic signed [AW-1:0] w_sum [3];
    logic signed [C-1:0]  n_pt [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_sum[j] = AW'(r9_o[j]) + AW'(r9_p[j] >>> DIST_FRAC);
            if (w_sum[j] > SAT_HI) begin
                n_pt[j] = C'(SAT_HI);
            end else if (w_sum[j] < SAT_LO) begin
                n_pt[j] = C'(SAT_LO);
            end else begin
                n_pt[j] = C'(w_sum[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hit  <= r9_hit;
            r_dist <= r9_dist;
            r_pt   <= n_pt;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            r6_v    <= 1'b0;
            r7_v    <= 1'b0;
            r8_v    <= 1'b0;
            r9_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r1_v    <= i_in_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r5_v    <= r4_v;
            r6_v    <= r5_v;
            r7_v    <= r6_v;
            r8_v    <= w_dv;
            r9_v    <= r8_v;
            r_out_v <= r9_v;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_hit       = r_hit;
    assign o_distance  = r_dist;
    assign o_point_x   = r_pt[0];
    assign o_point_y   = r_pt[1];
    assign o_point_z   = r_pt[2];

endmodule

>>> design/rti_div_pipe.sv
// ----------------------------------------------------------------------------
// rti_div_pipe
// Restoring divider, one quotient bit per register stage, with a side
// channel that travels alongside the quotient.
// ----------------------------------------------------------------------------
module rti_div_pipe #(
    parameter int MAG_W  = 66,
    parameter int SIDE_W = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [MAG_W+rti_pkg::QUO_BITS-1:0]    i_rem,
    input  logic [MAG_W-1:0]                      i_den,
    input  logic [SIDE_W-1:0]                     i_side,
    output logic                                  o_valid,
    output logic [rti_pkg::QUO_BITS-1:0]          o_quo,
    output logic [SIDE_W-1:0]                     o_side
);
    import rti_pkg::*;

    localparam int REM_W = MAG_W + QUO_BITS;

    logic             r_v    [QUO_BITS];
    logic [REM_W-1:0] r_rem  [QUO_BITS];
    logic [MAG_W-1:0] r_den  [QUO_BITS];
    logic [QUO_BITS-1:0] r_quo [QUO_BITS];
    logic [SIDE_W-1:0] r_side [QUO_BITS];

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
        localparam int BIT = QUO_BITS - 1 - k;
        logic             w_v;
        logic [REM_W-1:0] w_rem;
        logic [MAG_W-1:0] w_den;
        logic [QUO_BITS-1:0] w_quo;
        logic [SIDE_W-1:0] w_side;
        logic [REM_W-1:0] w_ds;
        logic [REM_W-1:0] n_rem;
        logic [QUO_BITS-1:0] n_quo;

        if (k == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_rem  = i_rem;
            assign w_den  = i_den;
            assign w_quo  = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v    = r_v[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_den  = r_den[k-1];
            assign w_quo  = r_quo[k-1];
            assign w_side = r_side[k-1];
        end

        always_comb begin
            w_ds  = REM_W'(w_den) << BIT;
            n_rem = w_rem;
            n_quo = w_quo;
            if (w_rem >= w_ds) begin
                n_rem = w_rem - w_ds;
                n_quo = w_quo | (QUO_BITS'(1) << BIT);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_den[k]  <= w_den;
                r_quo[k]  <= n_quo;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_v[QUO_BITS-1];
    assign o_quo   = r_quo[QUO_BITS-1];
    assign o_side  = r_side[QUO_BITS-1];

endmodule

>>> tb/ray_triangle_intersect_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_triangle_intersect_test
// Self-checking bench for the fixed-point ray/triangle intersection block.
// A directed table covers the zero triangle after reset, field extremes,
// hits, misses, a ray behind the origin, parallel rays and saturation. Random
// rays follow, most aimed inside the triangle, over four vertex settings
// and three handshake pressure patterns. Each result is compared against an
// exact-integer predictor, or against the typed expectation of a directed miss.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_test;
    import rti_pkg::*;

    localparam int CB        = 20;
    localparam int ONE       = 4096;
    localparam int DOG_LIMIT = 20000;
    localparam int N_RESET   = 4;
    localparam int N_ROWS    = 14;
    localparam int N_RANDOM  = 160;

    typedef logic signed [127:0] t_wide;
    typedef logic signed [CB-1:0] t_coord;

    typedef struct {
        t_coord ox, oy, oz, dx, dy, dz;
    } t_ray;

    typedef struct {
        logic                     hit;
        logic signed [DIST_W-1:0] distance;
        t_coord                   px, py, pz;
    } t_ray_result;

    typedef struct {
        t_ray        ray;
        bit          typed;
        t_ray_result want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_coord i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    t_coord i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic o_hit;
    logic signed [DIST_W-1:0] o_distance;
    t_coord o_point_x, o_point_y, o_point_z;

    logic [VERTEX_W-1:0] vtx [3];
    t_ray_result pending_results [$];
    t_row        rows [N_ROWS];
    int          in_idle_pct  = 0;
    int          out_idle_pct = 0;
    int          mismatches   = 0;
    int          results_seen = 0;
    int          hits_seen    = 0;
    int          rays_sent    = 0;
    int          dog          = 0;

    always #4 i_clk = ~i_clk;

    ray_triangle_intersect u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_origin_x(i_origin_x), .i_origin_y(i_origin_y), .i_origin_z(i_origin_z),
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_dir_z(i_dir_z),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_hit(o_hit), .o_distance(o_distance),
        .o_point_x(o_point_x), .o_point_y(o_point_y), .o_point_z(o_point_z)
    );

    function automatic longint vcoord(logic [VERTEX_W-1:0] r, int k);
        t_coord c;
        c = r[CB*k +: CB];
        return longint'(c);
    endfunction

    function automatic t_coord clip(longint x);
        if (x > 524287) return t_coord'(524287);
        if (x < -524288) return t_coord'(-524288);
        return t_coord'(x);
    endfunction

    function automatic t_ray mk_ray(longint ox, oy, oz, dx, dy, dz);
        t_ray r;
        r.ox = clip(ox); r.oy = clip(oy); r.oz = clip(oz);
        r.dx = clip(dx); r.dy = clip(dy); r.dz = clip(dz);
        return r;
    endfunction

    function automatic logic [VERTEX_W-1:0] pack_vtx(longint x, y, z);
        return {clip(z), clip(y), clip(x)};
    endfunction

    // Moller-Trumbore with exact integers; sign tests decide the hit without a division.
    function automatic t_ray_result trace_ray(t_ray r);
        longint a[3], e0[3], e1[3], s[3], o[3], dv[3], pv[3], qv[3];
        t_wide det, tn, u, v, rest;
        logic [127:0] nm, dm, q;
        longint tq, p;
        bit dneg;
        t_ray_result res;
        o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
        dv[0] = r.dx; dv[1] = r.dy; dv[2] = r.dz;
        for (int k = 0; k < 3; k++) begin
            a[k]  = vcoord(vtx[0], k);
            e0[k] = vcoord(vtx[1], k) - a[k];
            e1[k] = vcoord(vtx[2], k) - a[k];
            s[k]  = o[k] - a[k];
        end
        pv[0] = dv[1] * e1[2] - dv[2] * e1[1];
        pv[1] = dv[2] * e1[0] - dv[0] * e1[2];
        pv[2] = dv[0] * e1[1] - dv[1] * e1[0];
        qv[0] = s[1] * e0[2] - s[2] * e0[1];
        qv[1] = s[2] * e0[0] - s[0] * e0[2];
        qv[2] = s[0] * e0[1] - s[1] * e0[0];
        det = t_wide'(pv[0]) * t_wide'(e0[0]) + t_wide'(pv[1]) * t_wide'(e0[1])
            + t_wide'(pv[2]) * t_wide'(e0[2]);
        tn  = t_wide'(qv[0]) * t_wide'(e1[0]) + t_wide'(qv[1]) * t_wide'(e1[1])
            + t_wide'(qv[2]) * t_wide'(e1[2]);
        u   = t_wide'(pv[0]) * t_wide'(s[0]) + t_wide'(pv[1]) * t_wide'(s[1])
            + t_wide'(pv[2]) * t_wide'(s[2]);
        v   = t_wide'(qv[0]) * t_wide'(dv[0]) + t_wide'(qv[1]) * t_wide'(dv[1])
            + t_wide'(qv[2]) * t_wide'(dv[2]);
        res.hit = 1'b0;
        tq = 0;
        if (det != 0) begin
            dneg = det < 0;
            rest = det - u - v;
            res.hit = (u == 0 || (u < 0) == dneg) && (v == 0 || (v < 0) == dneg) &&
                      (rest == 0 || (rest < 0) == dneg) && (tn == 0 || (tn < 0) == dneg);
            nm = (tn < 0) ? -tn : tn;
            dm = dneg ? -det : det;
            if (nm >= (dm << 15))
                q = 128'h8000_0000;
            else
                q = (nm << DIST_FRAC) / dm;
            if ((tn < 0) != dneg)
                tq = -longint'(q);
            else
                tq = (q > 128'h7FFF_FFFF) ? 64'h7FFF_FFFF : longint'(q);
        end
        res.distance = tq;
        for (int k = 0; k < 3; k++) begin
            p = (tq * dv[k]) >>> DIST_FRAC;
            o[k] = o[k] + p;
        end
        res.px = clip(o[0]); res.py = clip(o[1]); res.pz = clip(o[2]);
        return res;
    endfunction

    task automatic apb_write(t_reg_idx idx, logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= APB_AW'(8 * int'(idx)); pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        vtx[idx] = data[VERTEX_W-1:0];
    endtask

    task automatic set_triangle(logic [VERTEX_W-1:0] va, vb, vc);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
        apb_write(REG_VERTEX_A, {4'($urandom_range(15)), va});
        apb_write(REG_VERTEX_B, {4'($urandom_range(15)), vb});
        apb_write(REG_VERTEX_C, {4'($urandom_range(15)), vc});
    endtask

    task automatic send_ray(t_ray r, bit typed, t_ray_result want);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_origin_x <= r.ox; i_origin_y <= r.oy; i_origin_z <= r.oz;
        i_dir_x <= r.dx; i_dir_y <= r.dy; i_dir_z <= r.dz;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(typed ? want : trace_ray(r));
        rays_sent++;
    endtask

    function automatic longint rnd_full();
        return longint'(t_coord'($urandom));
    endfunction

    function automatic longint rnd_near(int span);
        return longint'($urandom_range(2 * span)) - span;
    endfunction

    task automatic random_rays(int n);
        t_ray r;
        t_ray_result none;
        longint o[3], tgt[3];
        int w1, w2, sel;
        none = '{default: '0};
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            w1 = $urandom_range(256);
            w2 = $urandom_range(256 - w1);
            for (int k = 0; k < 3; k++) begin
                o[k] = rnd_near(16 * ONE);
                tgt[k] = vcoord(vtx[0], k)
                       + ((vcoord(vtx[1], k) - vcoord(vtx[0], k)) * w1
                       +  (vcoord(vtx[2], k) - vcoord(vtx[0], k)) * w2) / 256;
            end
            if (sel < 60)
                r = mk_ray(o[0], o[1], o[2], tgt[0] - o[0], tgt[1] - o[1], tgt[2] - o[2]);
            else if (sel < 85)
                r = mk_ray(rnd_full(), rnd_full(), rnd_full(),
                           rnd_full(), rnd_full(), rnd_full());
            else
                r = mk_ray(o[0], o[1], o[2], rnd_near(ONE), rnd_near(ONE), rnd_near(ONE));
            send_ray(r, 1'b0, none);
        end
        i_in_valid <= 1'b0;
    endtask

    function automatic t_row typed_miss(t_ray r);
        t_row t;
        t.ray = r;
        t.typed = 1'b1;
        t.want.hit = 1'b0;
        t.want.distance = '0;
        t.want.px = r.ox; t.want.py = r.oy; t.want.pz = r.oz;
        return t;
    endfunction

    function automatic t_row checked(t_ray r);
        t_row t;
        t.ray = r;
        t.typed = 1'b0;
        t.want = '{default: '0};
        return t;
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    always @(posedge i_clk) begin
        t_ray_result w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (o_hit) hits_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
            end else begin
                w = pending_results.pop_front();
                if (o_hit !== w.hit || o_distance !== w.distance || o_point_x !== w.px ||
                    o_point_y !== w.py || o_point_z !== w.pz) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch at %0t: exp hit=%0b t=%0d p=(%0d,%0d,%0d)",
                                  " got hit=%0b t=%0d p=(%0d,%0d,%0d)"},
                                 $realtime, w.hit, w.distance, w.px, w.py, w.pz,
                                 o_hit, o_distance, o_point_x, o_point_y, o_point_z);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            dog <= 0;
        else if (dog >= DOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else
            dog <= dog + 1;
    end

    initial begin
        vtx[0] = '0; vtx[1] = '0; vtx[2] = '0;
        // zero triangle after reset: det is zero, result is the origin
        rows[0]  = typed_miss(mk_ray(524287, 524287, 524287, 524287, 524287, 524287));
        rows[1]  = typed_miss(mk_ray(-524288, -524288, -524288, -524288, -524288, -524288));
        rows[2]  = typed_miss(mk_ray(0, 0, 0, 0, 0, 0));
        rows[3]  = typed_miss(mk_ray(524287, -524288, 1, -524288, 524287, -1));
        // triangle at z = 5 around the z axis
        rows[4]  = checked(mk_ray(0, 0, 0, 0, 0, ONE));
        rows[5]  = checked(mk_ray(0, 0, 0, -ONE, -ONE, 5 * ONE));
        rows[6]  = checked(mk_ray(0, 0, 0, 0, -ONE, 5 * ONE));
        rows[7]  = checked(mk_ray(0, 0, 10 * ONE, 0, 0, ONE));
        rows[8]  = checked(mk_ray(0, 0, 0, 0, 0, 1));
        rows[9]  = checked(mk_ray(0, 0, 0, 0, 0, -1));
        rows[10] = typed_miss(mk_ray(3 * ONE, 2 * ONE, 0, ONE, 0, 0));
        rows[11] = checked(mk_ray(0, 0, 0, 4 * ONE, 4 * ONE, 5 * ONE));
        rows[12] = checked(mk_ray(-524288, -524288, -524288, 524287, 524287, 524287));
        rows[13] = checked(mk_ray(524287, 0, 0, ONE, 0, ONE));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_idle_pct = 37; out_idle_pct = 85;
        for (int i = 0; i < N_ROWS; i++) begin
            if (i == N_RESET) begin
                i_in_valid <= 1'b0;
                set_triangle(pack_vtx(-ONE, -ONE, 5 * ONE), pack_vtx(ONE, -ONE, 5 * ONE),
                             pack_vtx(0, ONE, 5 * ONE));
            end
            send_ray(rows[i].ray, rows[i].typed, rows[i].want);
        end
        i_in_valid <= 1'b0;

        set_triangle(pack_vtx(rnd_near(16 * ONE), rnd_near(16 * ONE), rnd_near(16 * ONE)),
                     pack_vtx(rnd_near(16 * ONE), rnd_near(16 * ONE), rnd_near(16 * ONE)),
                     pack_vtx(rnd_near(16 * ONE), rnd_near(16 * ONE), rnd_near(16 * ONE)));
        random_rays(N_RANDOM);

        in_idle_pct = 85; out_idle_pct = 37;
        set_triangle(pack_vtx(-524288, -524288, 524287), pack_vtx(524287, -524288, -524288),
                     pack_vtx(-524288, 524287, -524288));
        random_rays(N_RANDOM);

        in_idle_pct = 0; out_idle_pct = 0;
        set_triangle(pack_vtx(rnd_full(), rnd_full(), rnd_full()),
                     pack_vtx(rnd_full(), rnd_full(), rnd_full()),
                     pack_vtx(rnd_full(), rnd_full(), rnd_full()));
        random_rays(N_RANDOM / 2);
        set_triangle(pack_vtx(rnd_near(4 * ONE), rnd_near(4 * ONE), rnd_near(4 * ONE)),
                     pack_vtx(rnd_near(4 * ONE), rnd_near(4 * ONE), rnd_near(4 * ONE)),
                     pack_vtx(rnd_near(4 * ONE), rnd_near(4 * ONE), rnd_near(4 * ONE)));
        random_rays(N_RANDOM / 2);

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("%0d rays over 6 triangles and 3 pressure patterns; %0d results, %0d hits",
                 rays_sent, results_seen, hits_seen);
        $display("%0d mismatches, %0d results outstanding", mismatches,
                 pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
design/rti_pkg.sv
design/rti_div_pipe.sv
design/ray_triangle_intersect.sv
tb/ray_triangle_intersect_test.sv
